### hdl/swhc_pkg.sv
// Shared types and constants for the sliding window hit counter.
`default_nettype none
package swhc_pkg;

  localparam int TS_W  = 32;
  localparam int CNT_W = 32;
  localparam int SUM_W = 41;
  localparam int WINDOW_SECONDS_DEF = 300;

  typedef struct packed {
    logic [TS_W-1:0]  sec;
    logic [CNT_W-1:0] cnt;
  } bucket_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_UPD,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } st_t;

endpackage
`default_nettype wire

### hdl/sliding_window_hit_counter_top.sv
// Sliding window hit counter: bucket memory, slot divider and window sum sweep.
`default_nettype none
// A request is taken when start is high and busy is low; busy stays high until the
// result has been shown. One result per request appears on out_window_count for a
// single cycle with out_valid high, and the receiver cannot stall it. A query
// (in_op = 0) goes straight to the window sum; a hit (in_op = 1) first finds the
// slot index by a reciprocal multiplication at acceptance and one correction step,
// and the bucket is then read and written back. The window sum reads every bucket
// through the single read port of the bucket memory, one bucket per cycle, which
// takes the bulk of the time of a request.
// After reset, busy stays high while the memory is cleared.
module sliding_window_hit_counter_top #(
  parameter int WINDOW_SECONDS = swhc_pkg::WINDOW_SECONDS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_op,
  input  wire logic [swhc_pkg::TS_W-1:0]  in_timestamp,
  output logic                            out_valid,
  output logic [swhc_pkg::SUM_W-1:0]      out_window_count
);

  localparam int SLOT_W = $clog2(WINDOW_SECONDS);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(WINDOW_SECONDS - 1);
  localparam logic [SLOT_W:0] WIN_EXT = (SLOT_W + 1)'(WINDOW_SECONDS);
  localparam logic [swhc_pkg::TS_W:0] WIN_TS = (swhc_pkg::TS_W + 1)'(WINDOW_SECONDS);
  localparam logic [swhc_pkg::SUM_W-1:0] SUM_MAX = '1;
  localparam logic [swhc_pkg::CNT_W-1:0] CNT_MAX = '1;
  // Reciprocal of the window, scaled so the quotient estimate is low by at most one
  localparam int PROD_W = 2 * swhc_pkg::TS_W;
  localparam int RECIP_SH = swhc_pkg::TS_W - 1 + SLOT_W;
  localparam logic [PROD_W-1:0] RECIP_FULL =
    (PROD_W'(1) << RECIP_SH) / PROD_W'(WINDOW_SECONDS);
  localparam logic [swhc_pkg::TS_W-1:0] RECIP = RECIP_FULL[swhc_pkg::TS_W-1:0];

  swhc_pkg::bucket_t mem [WINDOW_SECONDS];

  swhc_pkg::st_t state_r, state_nxt;
  logic [SLOT_W-1:0]            idx_r, idx_nxt;
  logic                         acc_en_r, acc_en_nxt;

  logic [swhc_pkg::TS_W-1:0]    ts_r;
  logic [PROD_W-1:0]            prod_r;
  logic [SLOT_W-1:0]            rem_r;
  logic [swhc_pkg::SUM_W-1:0]   acc_r;
  swhc_pkg::bucket_t            rdata_r;

  logic                         accept;
  logic                         mem_we, mem_re;
  logic [SLOT_W-1:0]            waddr, raddr;
  swhc_pkg::bucket_t            wdata, upd_bucket;
  logic [SLOT_W:0]              quo_lo;
  logic [SLOT_W:0]              quo_mul;
  logic [SLOT_W:0]              rem_est;
  logic [SLOT_W:0]              rem_sub;
  logic                         in_window;
  logic [swhc_pkg::SUM_W:0]     acc_sum;

  assign accept = start && (state_r == swhc_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swhc_pkg::ST_CLR:   if (idx_r == LAST_IDX) state_nxt = swhc_pkg::ST_IDLE;
      swhc_pkg::ST_IDLE: begin
        if (start) state_nxt = in_op ? swhc_pkg::ST_MOD : swhc_pkg::ST_SCAN;
      end
      swhc_pkg::ST_MOD:   state_nxt = swhc_pkg::ST_RD;
      swhc_pkg::ST_RD:    state_nxt = swhc_pkg::ST_UPD;
      swhc_pkg::ST_UPD:   state_nxt = swhc_pkg::ST_SCAN;
      swhc_pkg::ST_SCAN:  if (idx_r == LAST_IDX) state_nxt = swhc_pkg::ST_DRAIN;
      swhc_pkg::ST_DRAIN: state_nxt = swhc_pkg::ST_FIN;
      swhc_pkg::ST_FIN:   state_nxt = swhc_pkg::ST_IDLE;
      default:            state_nxt = swhc_pkg::ST_IDLE;
    endcase
  end

  // Bucket update: restamp on a new second, else saturating increment
  always_comb begin
    upd_bucket = rdata_r;
    if (rdata_r.sec != ts_r) begin
      upd_bucket.sec = ts_r;
      upd_bucket.cnt = swhc_pkg::CNT_W'(1);
    end else if (rdata_r.cnt != CNT_MAX) begin
      upd_bucket.cnt = rdata_r.cnt + swhc_pkg::CNT_W'(1);
    end
  end

  // Outputs and memory control
  always_comb begin
    busy        = (state_r != swhc_pkg::ST_IDLE);
    out_valid   = (state_r == swhc_pkg::ST_FIN);
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    waddr       = idx_r;
    raddr       = idx_r;
    wdata       = '0;
    idx_nxt     = idx_r;
    acc_en_nxt  = 1'b0;
    case (state_r)
      swhc_pkg::ST_CLR: begin
        mem_we  = 1'b1;
        idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + SLOT_W'(1);
      end
      swhc_pkg::ST_IDLE: begin
        idx_nxt     = '0;
      end
      swhc_pkg::ST_RD: begin
        mem_re = 1'b1;
        raddr  = rem_r;
      end
      swhc_pkg::ST_UPD: begin
        mem_we = 1'b1;
        waddr  = rem_r;
        wdata  = upd_bucket;
      end
      swhc_pkg::ST_SCAN: begin
        mem_re     = 1'b1;
        acc_en_nxt = 1'b1;
        idx_nxt    = (idx_r == LAST_IDX) ? '0 : idx_r + SLOT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Slot index: the remainder lies below twice the window, so only the low bits
  // matter; one compare and subtract finishes it
  assign quo_lo  = prod_r[RECIP_SH +: SLOT_W + 1];
  assign quo_mul = quo_lo * WIN_EXT;
  assign rem_est = ts_r[SLOT_W:0] - quo_mul;
  assign rem_sub = rem_est - WIN_EXT;

  // Window test at full width, then saturating accumulate
  assign in_window = ({1'b0, rdata_r.sec} + WIN_TS) > {1'b0, ts_r};
  assign acc_sum   = {1'b0, acc_r} + (swhc_pkg::SUM_W + 1)'(rdata_r.cnt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= swhc_pkg::ST_CLR;
      idx_r     <= '0;
      acc_en_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      acc_en_r  <= acc_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ts_r   <= in_timestamp;
      prod_r <= PROD_W'(in_timestamp) * PROD_W'(RECIP);
      rem_r  <= '0;
      acc_r  <= '0;
    end else begin
      if (state_r == swhc_pkg::ST_MOD) begin
        rem_r <= (rem_est >= WIN_EXT) ? rem_sub[SLOT_W-1:0] : rem_est[SLOT_W-1:0];
      end
      if (acc_en_r && in_window) begin
        acc_r <= acc_sum[swhc_pkg::SUM_W] ? SUM_MAX : acc_sum[swhc_pkg::SUM_W-1:0];
      end
    end
  end

  // Bucket memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign out_window_count = acc_r;

endmodule
`default_nettype wire

### hdl/swhc_chk.sv
// Port-level checker for the sliding window hit counter, bound to the top level.
`default_nettype none
module swhc_chk (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      out_valid,
  input wire logic [swhc_pkg::SUM_W-1:0] out_window_count
);

  logic seen_idle_r;

  // Mark the end of the clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_idle_r <= 1'b0;
    end else if (!busy) begin
      seen_idle_r <= 1'b1;
    end
  end

  // A result only shows while the request is still in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // Strobe lasts one cycle and frees the block right after
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe not a single cycle");

  // An accepted request holds the block busy with no result yet
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("request accepted but block not busy");

  // Busy drops only through a result strobe, except at the end of the clearing pass
  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && seen_idle_r) |-> $past(out_valid))
    else $error("busy fell unexpectedly");

  // A shown result is always fully defined
  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_window_count))
    else $error("result has unknown bits");

endmodule

bind sliding_window_hit_counter_top swhc_chk u_swhc_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_window_count (out_window_count)
);
`default_nettype wire

### test/tb_sliding_window_hit_counter_top.sv
// Testbench for sliding_window_hit_counter_top: directed and random hits and queries vs a scoreboard.
`timescale 1ns / 100ps
module tb_sliding_window_hit_counter_top;

  localparam int unsigned WIN = swhc_pkg::WINDOW_SECONDS_DEF;
  localparam int TS_W = swhc_pkg::TS_W;
  localparam int CNT_W = swhc_pkg::CNT_W;
  localparam int SUM_W = swhc_pkg::SUM_W;
  localparam int RANDOM_ITEMS = 800;
  localparam int STALL_LIMIT = 4000;

  typedef enum logic { OP_QUERY = 1'b0, OP_HIT = 1'b1 } req_op_t;

  typedef struct {
    logic [SUM_W-1:0] count;
    logic [TS_W-1:0]  ts;
    logic             op;
  } window_expect_t;

  class hit_window_board;
    logic [TS_W-1:0]  slot_second [WIN];
    logic [CNT_W-1:0] slot_hits [WIN];
    window_expect_t   pending_counts [$];
    int unsigned      errors;

    function new();
      for (int i = 0; i < WIN; i++) begin
        slot_second[i] = '0;
        slot_hits[i] = '0;
      end
      errors = 0;
    endfunction

    function void note_request(logic op, logic [TS_W-1:0] ts);
      int unsigned slot;
      logic [63:0] total;
      logic [63:0] limit_sec;
      logic [63:0] sum_max;
      window_expect_t e;
      sum_max = (64'd1 << SUM_W) - 64'd1;
      slot = ts % WIN;
      if (op == OP_HIT) begin
        if (slot_second[slot] != ts) begin
          slot_second[slot] = ts;
          slot_hits[slot] = 1;
        end else if (slot_hits[slot] != {CNT_W{1'b1}}) begin
          slot_hits[slot] = slot_hits[slot] + 1'b1;
        end
      end
      total = '0;
      for (int i = 0; i < WIN; i++) begin
        // form the window edge wide so it never wraps
        limit_sec = {32'd0, slot_second[i]} + 64'(WIN);
        if (limit_sec > {32'd0, ts}) begin
          total = total + {32'd0, slot_hits[i]};
          if (total > sum_max) total = sum_max;
        end
      end
      e.count = total[SUM_W-1:0];
      e.ts = ts;
      e.op = op;
      pending_counts.push_back(e);
    endfunction

    task report(string msg);
      $display("%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [SUM_W-1:0] got);
      window_expect_t e;
      if (pending_counts.size() == 0) begin
        report($sformatf("unexpected result window_count=%0d", got));
        return;
      end
      e = pending_counts.pop_front();
      if (got !== e.count)
        report($sformatf("window_count mismatch op=%0d ts=%0d: expected %0d, got %0d",
                         e.op, e.ts, e.count, got));
    endtask

    function int unsigned outstanding();
      return pending_counts.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_op = 1'b0;
  logic [TS_W-1:0] in_timestamp = '0;
  logic busy;
  logic out_valid;
  logic [SUM_W-1:0] out_window_count;

  hit_window_board board = new();
  bit may_idle = 1'b1;
  int stall_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sliding_window_hit_counter_top #(
    .WINDOW_SECONDS(WIN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_timestamp(in_timestamp),
    .out_valid(out_valid),
    .out_window_count(out_window_count)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) board.check_result(out_window_count);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_sliding_window_hit_counter_top failed");
      $finish;
    end
  end

  // Hold the request until it is taken; while may_idle is set, drop start at random cycles, busy or not.
  task automatic issue_request(input logic op, input logic [TS_W-1:0] ts);
    logic taken;
    taken = 1'b0;
    in_op <= op;
    in_timestamp <= ts;
    while (!taken) begin
      start <= !(may_idle && $urandom_range(0, 99) < 27);
      @(posedge clk);
      taken = start && (busy === 1'b0);
    end
    board.note_request(op, ts);
  endtask

  initial begin
    logic [TS_W-1:0] now;
    int unsigned r;
    logic op;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // fresh memory, timestamp zero, window edge, decreasing time, top of range
    issue_request(OP_QUERY, 32'd0);
    issue_request(OP_HIT, 32'd0);
    issue_request(OP_HIT, 32'd0);
    issue_request(OP_QUERY, 32'd299);
    issue_request(OP_QUERY, 32'd300);
    issue_request(OP_HIT, 32'd300);
    issue_request(OP_HIT, 32'd599);
    issue_request(OP_HIT, 32'd599);
    issue_request(OP_QUERY, 32'd0);
    issue_request(OP_HIT, 32'hFFFF_FFFF);
    issue_request(OP_HIT, 32'hFFFF_FFFF);
    issue_request(OP_QUERY, 32'hFFFF_FFFE);
    issue_request(OP_HIT, 32'hFFFF_FF00);
    issue_request(OP_QUERY, 32'hFFFF_FFFF);
    issue_request(OP_HIT, 32'h8000_0000);
    issue_request(OP_HIT, 32'h7FFF_FFFF);
    issue_request(OP_HIT, 32'h5555_5555);
    issue_request(OP_HIT, 32'hAAAA_AAAA);
    issue_request(OP_QUERY, 32'hAAAA_AAAA);
    issue_request(OP_QUERY, 32'd0);
    issue_request(OP_HIT, 32'd12);
    issue_request(OP_QUERY, 32'd311);

    now = $urandom;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      may_idle = !(n >= 300 && n < 500);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // noise: any timestamp, often going backward
        op = 1'($urandom_range(0, 1));
        issue_request(op, $urandom);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) now = now;
        else if (r < 80) now = now + $urandom_range(1, 3);
        else if (r < 93) now = now + $urandom_range(4, 60);
        else if (r < 98) now = now + $urandom_range(250, 350);
        else if (r < 99) now = now + $urandom_range(1000, 100000);
        else now = 32'hFFFF_FFFF - $urandom_range(0, 500);
        op = ($urandom_range(0, 99) < 75) ? OP_HIT : OP_QUERY;
        issue_request(op, now);
      end
    end
    start <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (2 * WIN + 40) @(posedge clk);

    if (board.errors == 0) begin
      $display("tb_sliding_window_hit_counter_top passed");
    end else begin
      $display("tb_sliding_window_hit_counter_top failed");
    end
    $finish;
  end

endmodule
